### rtl/core/i2cm_pkg.sv
// Package for the I2C master byte engine.
// Holds the command codes, register indexes, bus phases and the result record.
// No dependencies.
package i2cm_pkg;

    // Commands carried by an input transaction.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_START_STOP = 2'd0,
        CFG_BIT_HALF   = 2'd1,
        CFG_ACK_TMO    = 2'd2
    } t_cfg_idx;

    localparam int unsigned TICK_W = 10;
    localparam int unsigned POLL_W = 8;
    localparam int unsigned CFG_W  = 10;

    localparam logic [TICK_W-1:0] START_STOP_RST = 10'd5;
    localparam logic [TICK_W-1:0] BIT_HALF_RST   = 10'd2;
    localparam logic [POLL_W-1:0] ACK_TMO_RST    = 8'd250;
    localparam logic [3:0]        BITS_PER_BYTE  = 4'd8;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_STOP_A   = 4'd3,
        PH_STOP_B   = 4'd4,
        PH_WR_LOW   = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_ACK_LOW  = 4'd7,
        PH_ACK_POLL = 4'd8,
        PH_RD_LOW   = 4'd9,
        PH_RD_HIGH  = 4'd10,
        PH_RAK_LOW  = 4'd11,
        PH_RAK_HIGH = 4'd12
    } t_phase;

    // One result per tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_result;

endpackage

### rtl/core/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine.
// Depends on i2cm_pkg, i2cm_seq and i2cm_obuf.
//
// Each input transaction is one timebase tick and yields exactly one result
// transaction, one tick per clock cycle while o_stall is low. The tick is
// processed in the cycle it is accepted, updating the sequencer state, and
// its result is registered in the output buffer. A two-entry output buffer
// lets the engine keep taking ticks while a result waits, and o_stall rises
// only when both buffer entries are held by a stalled output.
// Configuration writes are taken in any cycle and should be made while idle.
module i2c_master_byte_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [2:0]                 i_action,
    input  logic [7:0]                 i_tx_byte,
    input  logic                       i_send_ack,
    input  logic                       i_sda_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_scl_out,
    output logic                       o_sda_out,
    output logic                       o_busy_res,
    output logic                       o_done_res,
    output logic [7:0]                 o_rx_byte,
    output logic                       o_ack_failed
);
    import i2cm_pkg::*;

    t_result seq_res, out_res;
    logic    buf_full;
    logic    step;

    // A tick is taken whenever the output buffer has room.
    assign step    = i_valid && !buf_full;
    assign o_stall = buf_full;

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_action    (i_action),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .o_res       (seq_res)
    );

    i2cm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_res   (seq_res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_scl_out    = out_res.scl_out;
    assign o_sda_out    = out_res.sda_out;
    assign o_busy_res   = out_res.busy_res;
    assign o_done_res   = out_res.done_res;
    assign o_rx_byte    = out_res.rx_byte;
    assign o_ack_failed = out_res.ack_failed;

endmodule

### rtl/core/i2cm_seq.sv
// Bus sequencer: configuration registers, phase state and the per-tick update.
// Depends on i2cm_pkg.
module i2cm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [i2cm_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_step,
    input  logic [2:0]                    i_action,
    input  logic [7:0]                    i_tx_byte,
    input  logic                          i_send_ack,
    input  logic                          i_sda_in,
    output i2cm_pkg::t_result             o_res
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] r_ss_ticks, r_bh_ticks;
    logic [POLL_W-1:0] r_ack_tmo;

    t_phase            r_phase, e_phase, n_phase;
    logic [TICK_W-1:0] r_tick, e_tick, n_tick;
    logic [3:0]        r_bit, e_bit, n_bit;
    logic [7:0]        r_shift, e_shift, n_shift;
    logic [POLL_W-1:0] r_poll, e_poll, n_poll;
    logic              r_ack_choice, e_ack_choice;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_fail, e_fail, n_fail;
    logic [7:0]        r_rx, n_rx;
    logic              n_done;

    logic [TICK_W-1:0] lim;
    logic [TICK_W-1:0] tick_inc;
    logic              adv;
    logic [TICK_W-1:0] tick_adv;
    logic [3:0]        bit_inc;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ss_ticks <= START_STOP_RST;
            r_bh_ticks <= BIT_HALF_RST;
            r_ack_tmo  <= ACK_TMO_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_STOP: r_ss_ticks <= i_cfg_wdata[TICK_W-1:0];
                CFG_BIT_HALF:   r_bh_ticks <= i_cfg_wdata[TICK_W-1:0];
                CFG_ACK_TMO:    r_ack_tmo  <= i_cfg_wdata[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    // Command entry: an idle engine loads a new command and starts its first phase now.
    always_comb begin
        e_phase      = r_phase;
        e_tick       = r_tick;
        e_bit        = r_bit;
        e_shift      = r_shift;
        e_poll       = r_poll;
        e_ack_choice = r_ack_choice;
        e_fail       = r_fail;
        if (r_phase == PH_IDLE && i_action inside {[ACT_START:ACT_READ]}) begin
            e_tick = '0;
            e_bit  = '0;
            e_poll = '0;
            e_fail = 1'b0;
            case (i_action)
                ACT_START: e_phase = PH_START_A;
                ACT_STOP:  e_phase = PH_STOP_A;
                ACT_WRITE: begin
                    e_shift = i_tx_byte;
                    e_phase = PH_WR_LOW;
                end
                default: begin
                    e_shift      = '0;
                    e_ack_choice = i_send_ack;
                    e_phase      = PH_RD_LOW;
                end
            endcase
        end
    end

    // Phase timer: one increment and compare against the limit of the current phase.
    always_comb begin
        if (e_phase == PH_START_A || e_phase == PH_START_B ||
            e_phase == PH_STOP_A || e_phase == PH_STOP_B) begin
            lim = r_ss_ticks;
        end else begin
            lim = r_bh_ticks;
        end
        tick_inc = e_tick + 1'b1;
        adv      = (tick_inc >= lim);
        tick_adv = adv ? '0 : tick_inc;
        bit_inc  = e_bit + 1'b1;
    end

    // Phase update and bus levels for this tick.
    always_comb begin
        n_phase = e_phase;
        n_tick  = e_tick;
        n_bit   = e_bit;
        n_shift = e_shift;
        n_poll  = e_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_fail  = e_fail;
        n_rx    = r_rx;
        n_done  = 1'b0;
        case (e_phase)
            PH_IDLE: ;
            PH_START_A: begin
                n_scl  = 1'b1;
                n_sda  = 1'b1;
                n_tick = tick_adv;
                if (adv) n_phase = PH_START_B;
            end
            PH_START_B: begin
                n_scl  = 1'b1;
                n_sda  = 1'b0;
                n_tick = tick_adv;
                if (adv) begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_STOP_A: begin
                n_scl  = 1'b0;
                n_sda  = 1'b0;
                n_tick = tick_adv;
                if (adv) n_phase = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_scl  = 1'b1;
                n_sda  = 1'b1;
                n_tick = tick_adv;
                if (adv) begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            PH_WR_LOW, PH_WR_HIGH: begin
                n_sda  = e_shift[7];
                n_scl  = (e_phase == PH_WR_HIGH);
                n_tick = tick_adv;
                if (adv) begin
                    if (e_phase == PH_WR_LOW) begin
                        n_phase = PH_WR_HIGH;
                    end else begin
                        n_shift = {e_shift[6:0], 1'b0};
                        n_bit   = bit_inc;
                        n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_WR_LOW;
                    end
                end
            end
            PH_ACK_LOW: begin
                n_scl  = 1'b0;
                n_sda  = 1'b1;
                n_tick = tick_adv;
                if (adv) begin
                    n_phase = PH_ACK_POLL;
                    n_poll  = '0;
                end
            end
            PH_ACK_POLL: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
                if (!i_sda_in) begin
                    // Slave acknowledged: release the byte with SCL low.
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                    n_tick  = '0;
                end else if (e_poll >= r_ack_tmo) begin
                    // No acknowledge in time: flag it and close the bus with a stop.
                    n_fail  = 1'b1;
                    n_phase = PH_STOP_A;
                    n_tick  = '0;
                end else begin
                    n_poll = e_poll + 1'b1;
                end
            end
            PH_RD_LOW: begin
                n_scl  = 1'b0;
                n_sda  = 1'b1;
                n_tick = tick_adv;
                if (adv) n_phase = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
                n_scl = 1'b1;
                n_sda = 1'b1;
                // Sample SDA on the first tick of the SCL high half.
                if (e_tick == '0) n_shift = {e_shift[6:0], i_sda_in};
                n_tick = tick_adv;
                if (adv) begin
                    n_bit   = bit_inc;
                    n_phase = (bit_inc >= BITS_PER_BYTE) ? PH_RAK_LOW : PH_RD_LOW;
                end
            end
            PH_RAK_LOW, PH_RAK_HIGH: begin
                n_sda  = !e_ack_choice;
                n_scl  = (e_phase == PH_RAK_HIGH);
                n_tick = tick_adv;
                if (adv) begin
                    if (e_phase == PH_RAK_LOW) begin
                        n_phase = PH_RAK_HIGH;
                    end else begin
                        n_scl   = 1'b0;
                        n_rx    = e_shift;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_poll       <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_fail       <= 1'b0;
            r_rx         <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_ack_choice <= e_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_fail       <= n_fail;
            r_rx         <= n_rx;
        end
    end

    // Result of this tick, registered by the output buffer.
    always_comb begin
        o_res.scl_out    = n_scl;
        o_res.sda_out    = n_sda;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.done_res   = n_done;
        o_res.rx_byte    = n_rx;
        o_res.ack_failed = n_fail;
    end

endmodule

### rtl/core/i2cm_obuf.sv
// Two-entry output buffer: a result register plus a skid register.
// Depends on i2cm_pkg.
module i2cm_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cm_pkg::t_result i_res,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output i2cm_pkg::t_result o_res
);
    import i2cm_pkg::*;

    t_result r_head, r_skid;
    logic    r_head_vld, r_skid_vld;
    logic    pop;

    assign pop = r_head_vld && !i_stall;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_head_vld <= r_skid_vld || i_push;
                r_skid_vld <= 1'b0;
            end else if (i_push) begin
                if (r_head_vld) r_skid_vld <= 1'b1;
                else r_head_vld <= 1'b1;
            end
        end
    end

    // Payload moves; a push never meets a full skid register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_vld) r_head <= r_skid;
            else if (i_push) r_head <= i_res;
        end else if (i_push) begin
            if (r_head_vld) r_skid <= i_res;
            else r_head <= i_res;
        end
    end

    assign o_full  = r_skid_vld;
    assign o_valid = r_head_vld;
    assign o_res   = r_head;

endmodule

### rtl/core/i2cm_checker.sv
// Port-level checks for the I2C master byte engine.
// Depends on the top level's ports only; attached by the bind below.
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte
);

    // Reset empties the output buffer and reopens the input.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("buffer not empty after reset");

    // The input is only held off when a result is waiting.
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // A finishing tick leaves the engine idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    // A stalled result transaction holds its payload.
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rx_byte) && $stable(o_done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_busy_res (o_busy_res),
    .o_done_res (o_done_res),
    .o_rx_byte  (o_rx_byte)
);
